FILE: rtl/core/quadratic_discriminant_solver_top_defines.svh
// Assertion helpers for the top-level file that checks this block.
`ifndef QUADRATIC_DISCRIMINANT_SOLVER_TOP_DEFINES_SVH
`define QUADRATIC_DISCRIMINANT_SOLVER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QDS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/qds_pkg.sv
package qds_pkg;

  // Field widths
  localparam int COEF_W    = 24;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int DISC_W    = 2 * COEF_W + 3;
  localparam int TERM_W    = COEF_W + 1;
  localparam int ROOT_W    = COEF_W + 1;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int DEG_W     = 2;
  localparam int OUTC_W    = 3;

  // Square root pipeline: one result bit per stage
  localparam int SQ_STAGES = ROOT_W;

  // Queue between front and back
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // Stream payload layout
  localparam int IN_FIELDS_W  = 3 * COEF_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DEG_W + OUTC_W + DISC_W + 4 * TERM_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OFS_OUTC     = DEG_W;
  localparam int OFS_DISC     = OFS_OUTC + OUTC_W;
  localparam int OFS_ROOT     = OFS_DISC + DISC_W;

  // Degree codes
  localparam logic [DEG_W-1:0] DEG_CONST  = 2'd0;
  localparam logic [DEG_W-1:0] DEG_LINEAR = 2'd1;
  localparam logic [DEG_W-1:0] DEG_QUAD   = 2'd2;

  // Outcome codes
  localparam logic [OUTC_W-1:0] OUT_NO_REAL   = 3'd0;
  localparam logic [OUTC_W-1:0] OUT_DOUBLE    = 3'd1;
  localparam logic [OUTC_W-1:0] OUT_TWO_ROOTS = 3'd2;
  localparam logic [OUTC_W-1:0] OUT_LINEAR    = 3'd3;
  localparam logic [OUTC_W-1:0] OUT_ALL_REALS = 3'd4;
  localparam logic [OUTC_W-1:0] OUT_NONE      = 3'd5;

  // Classified item passed from front to back
  typedef struct packed {
    logic        [DEG_W-1:0]  degree;
    logic        [OUTC_W-1:0] outcome;
    logic signed [DISC_W-1:0] disc;
    logic signed [TERM_W-1:0] minus_b;
    logic signed [TERM_W-1:0] twice_a;
    logic signed [TERM_W-1:0] minus_c;
  } qds_item_t;

endpackage

FILE: rtl/core/qds_front.sv
module qds_front
  import qds_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // coef_a, coef_b, coef_c
  input  logic [IN_DATA_W-1:0] s_axis_tdata_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output qds_item_t            q_item_o
);

  logic adv;

  logic signed [COEF_W-1:0] coef_a, coef_b, coef_c;

  logic                     p_valid_q;
  logic signed [PROD_W-1:0] bb_q, ac_q;
  logic                     a_nz_q, b_nz_q, c_z_q;
  logic signed [TERM_W-1:0] minus_b_q, twice_a_q, minus_c_q;

  logic signed [DISC_W-1:0] disc_full;
  qds_item_t                item_d, item_q;
  logic                     d_valid_q;

  // Advance both stages unless a finished item cannot enter the queue
  assign adv             = !d_valid_q || !q_full_i;
  assign s_axis_tready_o = adv;

  assign coef_a = s_axis_tdata_i[COEF_W-1:0];
  assign coef_b = s_axis_tdata_i[2*COEF_W-1:COEF_W];
  assign coef_c = s_axis_tdata_i[3*COEF_W-1:2*COEF_W];

  // Stage valids for the product and discriminant stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (adv) begin
      p_valid_q <= s_axis_tvalid_i;
      d_valid_q <= p_valid_q;
    end
  end

  // Product stage: squares, cross product and root terms
  always_ff @(posedge clk_i) begin
    if (adv) begin
      bb_q      <= PROD_W'(coef_b) * PROD_W'(coef_b);
      ac_q      <= PROD_W'(coef_a) * PROD_W'(coef_c);
      a_nz_q    <= coef_a != '0;
      b_nz_q    <= coef_b != '0;
      c_z_q     <= coef_c == '0;
      minus_b_q <= -{coef_b[COEF_W-1], coef_b};
      twice_a_q <= {coef_a, 1'b0};
      minus_c_q <= -{coef_c[COEF_W-1], coef_c};
    end
  end

  // Discriminant stage: b*b - 4ac and classification
  assign disc_full = {{(DISC_W-PROD_W){bb_q[PROD_W-1]}}, bb_q}
                   - {ac_q[PROD_W-1], ac_q, 2'b00};

  always_comb begin
    item_d.minus_b = minus_b_q;
    item_d.twice_a = twice_a_q;
    item_d.minus_c = minus_c_q;
    item_d.disc    = '0;
    if (a_nz_q) begin
      item_d.degree = DEG_QUAD;
      item_d.disc   = disc_full;
      if (disc_full[DISC_W-1]) begin
        item_d.outcome = OUT_NO_REAL;
      end else if (disc_full == '0) begin
        item_d.outcome = OUT_DOUBLE;
      end else begin
        item_d.outcome = OUT_TWO_ROOTS;
      end
    end else if (b_nz_q) begin
      item_d.degree  = DEG_LINEAR;
      item_d.outcome = OUT_LINEAR;
    end else begin
      item_d.degree  = DEG_CONST;
      item_d.outcome = c_z_q ? OUT_ALL_REALS : OUT_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      item_q <= item_d;
    end
  end

  assign q_push_o = d_valid_q && !q_full_i;
  assign q_item_o = item_q;

endmodule

FILE: rtl/core/qds_queue.sv
module qds_queue
  import qds_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  qds_item_t item_i,
  input  logic      pop_i,
  output qds_item_t item_o,
  output logic      full_o,
  output logic      empty_o
);

  qds_item_t          mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o  = mem_q[rd_ptr_q];
  assign full_o  = cnt_q == Q_CNT_W'(Q_DEPTH);
  assign empty_o = cnt_q == '0;

endmodule

FILE: rtl/core/qds_back.sv
module qds_back
  import qds_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  qds_item_t             q_item_i,
  output logic                  q_pop_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // degree, outcome, discriminant, root_of_discriminant, minus_b, twice_a,
  // minus_c, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic adv;

  logic [SQ_STAGES-1:0] vld_q;
  logic [RAD_W-1:0]     rem_d [SQ_STAGES];
  logic [RAD_W-1:0]     res_d [SQ_STAGES];
  logic [RAD_W-1:0]     rem_q [SQ_STAGES];
  logic [RAD_W-1:0]     res_q [SQ_STAGES];
  qds_item_t            item_q [SQ_STAGES];
  logic [RAD_W-1:0]     radicand;
  qds_item_t            last_item;

  // Move the whole root pipe unless the output is held
  assign adv     = !vld_q[SQ_STAGES-1] || m_axis_tready_i;
  assign q_pop_o = q_valid_i && adv;

  // Only a positive discriminant needs a root; others feed zero
  assign radicand = (q_item_i.outcome == OUT_TWO_ROOTS) ? q_item_i.disc[RAD_W-1:0] : '0;

  // One restoring root step per stage, most significant result bit first
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_step
    localparam logic [RAD_W-1:0] STEP_BIT = RAD_W'(1) << (2 * (SQ_STAGES - 1 - k));

    logic [RAD_W-1:0] rem_in, res_in;
    logic [RAD_W:0]   trial;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in = radicand;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    assign trial    = {1'b0, res_in} + {1'b0, STEP_BIT};
    assign take     = {1'b0, rem_in} >= trial;
    assign rem_d[k] = take ? rem_in - trial[RAD_W-1:0] : rem_in;
    assign res_d[k] = take ? (res_in >> 1) + STEP_BIT : res_in >> 1;
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[SQ_STAGES-2:0], q_valid_i};
    end
  end

  // Stage payload: partial root, remainder and the item riding along
  always_ff @(posedge clk_i) begin
    if (adv) begin
      item_q[0] <= q_item_i;
      for (int k = 0; k < SQ_STAGES; k++) begin
        rem_q[k] <= rem_d[k];
        res_q[k] <= res_d[k];
      end
      for (int k = 1; k < SQ_STAGES; k++) begin
        item_q[k] <= item_q[k-1];
      end
    end
  end

  // Last stage is the output register
  assign last_item       = item_q[SQ_STAGES-1];
  assign m_axis_tvalid_o = vld_q[SQ_STAGES-1];
  assign m_axis_tdata_o  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}},
                            last_item.minus_c,
                            last_item.twice_a,
                            last_item.minus_b,
                            res_q[SQ_STAGES-1][ROOT_W-1:0],
                            last_item.disc,
                            last_item.outcome,
                            last_item.degree};

endmodule

FILE: rtl/core/quadratic_discriminant_solver_top.sv
// Channel   Dir  Payload (low bits first)                          Handshake
// s_axis    in   coef_a, coef_b, coef_c (24 b each)                tvalid/tready
// m_axis    out  degree, outcome, discriminant, root_of_discriminant,
//                minus_b, twice_a, minus_c, 4 b zero fill          tvalid/tready
//
// One item per cycle sustained while the output is ready; a result passes through
// two multiply/discriminant stages, one queue slot and 25 root stages of one bit each.
// The 25-stage root pipe sets the latency; every stage holds one item.
// Reset clears stage valids and the queue pointers; no clearing pass is needed.
// A held output freezes the root pipe; the front keeps taking items until its
// two stages and the four-entry queue are full.
`include "quadratic_discriminant_solver_top_defines.svh"

module quadratic_discriminant_solver_top
  import qds_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // coef_a, coef_b, coef_c
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // degree, outcome, discriminant, root_of_discriminant, minus_b, twice_a,
  // minus_c, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic      q_push, q_pop, q_full, q_empty;
  qds_item_t front_item, head_item;

  qds_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (front_item)
  );

  qds_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .item_i  (front_item),
    .pop_i   (q_pop),
    .item_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  qds_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (!q_empty),
    .q_item_i  (head_item),
    .q_pop_o   (q_pop),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  // Output fields seen by the checks
  logic [DEG_W-1:0]  out_deg;
  logic [OUTC_W-1:0] out_outc;
  logic [DISC_W-1:0] out_disc;
  logic [ROOT_W-1:0] out_root;

  assign out_deg  = m_axis_tdata_o[DEG_W-1:0];
  assign out_outc = m_axis_tdata_o[OFS_OUTC+OUTC_W-1:OFS_OUTC];
  assign out_disc = m_axis_tdata_o[OFS_DISC+DISC_W-1:OFS_DISC];
  assign out_root = m_axis_tdata_o[OFS_ROOT+ROOT_W-1:OFS_ROOT];

  `QDS_ASSERT_IMPL(a_two_roots_have_root, m_axis_tvalid_o && (out_outc == OUT_TWO_ROOTS), (out_root != '0) && !out_disc[DISC_W-1], "two roots without a root value")
  `QDS_ASSERT_IMPL(a_low_degree_zero, m_axis_tvalid_o && (out_deg != DEG_QUAD), (out_disc == '0) && (out_root == '0), "nonzero discriminant below degree two")
  `QDS_ASSERT_IMPL(a_no_real_negative, m_axis_tvalid_o && (out_outc == OUT_NO_REAL), out_disc[DISC_W-1] && (out_root == '0), "no real root with nonnegative discriminant")
  `QDS_ASSERT_NEXT(a_push_fills_queue, q_push && !q_pop, !q_empty, "queue empty after a push")

endmodule
